>>> design/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared constants, wave select codes and divider request and response types for the
// multi-mode waveform generator.
// ----------------------------------------------------------------------------
package wfg_pkg;

  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;

  localparam logic [11:0] DAC_MAX       = 12'd4095;
  localparam logic [13:0] DAC_CTRL      = 14'h3000;
  localparam logic [12:0] TRI_SPAN      = 13'd8190;
  localparam logic [15:0] SQUARE_FREQ   = 16'd100;
  localparam logic [15:0] RAMP_FREQ     = 16'd50;
  localparam logic [9:0]  HZ_SCALE      = 10'd900;
  localparam logic [9:0]  HZ_OFFSET     = 10'd100;
  localparam logic [15:0] TICK_RATE_RST = 16'd1000;

  // Divisions by a constant use a rounded-up reciprocal and a shift. Each
  // reciprocal gives the exact floor over the full range of its operand.
  localparam int          RECIP_SHIFT  = 24;
  localparam logic [17:0] SQUARE_RECIP = 18'd167773;  // 2^24 / 100
  localparam logic [18:0] RAMP_RECIP   = 19'd335545;  // 2^24 / 50
  localparam logic [4:0]  HZ_STEP      = 5'd20;       // 900/4095 reduces to 20/91
  localparam logic [17:0] HZ_RECIP     = 18'd184366;  // 2^24 / 91

  localparam logic [3:0] WAVE_LEVEL    = 4'd1;
  localparam logic [3:0] WAVE_SQUARE   = 4'd2;
  localparam logic [3:0] WAVE_SAW      = 4'd3;
  localparam logic [3:0] WAVE_TRI      = 4'd4;
  localparam logic [3:0] WAVE_TRI_VAR  = 4'd5;
  localparam logic [3:0] WAVE_FULL     = 4'd9;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } wfg_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic [DIVISOR_W-1:0]  rem;
  } wfg_div_rsp_t;

endpackage

>>> design/multi_mode_waveform_generator.sv
// ----------------------------------------------------------------------------
// multi_mode_waveform_generator
// Function generator: level, full-scale, square, sawtooth and fixed or tuned triangle outputs per tick.
// ----------------------------------------------------------------------------
// Per item: level, full scale, zero output and a zero fixed-rate period go
// straight to DONE; square divides once (MOD); sawtooth and triangle twice (MOD,
// SCALE); the scroll-tuned triangle up to three times (PER, MOD, SCALE), ending
// after PER on a zero tuned period. All share one 32-step divider. One item is in
// work at a time; in_tready is low until the result is loaded. Reset clears the
// wave select, loads a tick rate of 1000 and empties the output register.
module multi_mode_waveform_generator
  import wfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // tick_rate
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,       // time_count[31:0], scroll_level[43:32], zero pad
  input  logic [4:0]  in_tuser,       // key_pressed[0], key_value[4:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata       // dac_level[11:0], dac_word[25:12], zero pad
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PER   = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  wave_r, wave_nxt;
  logic [15:0] tick_rate_r;
  logic [31:0] time_r;
  logic [11:0] level_r;
  logic [15:0] period_r, period_nxt;
  logic [15:0] prog_r, prog_nxt;
  logic [11:0] res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_value_r;
  logic        out_load;

  wfg_div_req_t div_req;
  wfg_div_rsp_t div_rsp;

  logic        in_fire;
  logic [3:0]  in_wave;
  logic [11:0] in_level;
  logic [33:0] sq_prod;
  logic [34:0] ramp_prod;
  logic [15:0] sq_period;
  logic [15:0] ramp_period;
  logic [16:0] lvl_x20;
  logic [33:0] hz_prod;
  logic [9:0]  hz;
  logic [12:0] scale_k;
  logic [12:0] ramp_d;
  logic [12:0] tri_v;

  assign in_fire  = in_tvalid && in_tready;
  assign in_level = in_tdata[43:32];
  assign in_wave  = in_tuser[0] ? in_tuser[4:1] : wave_r;

  // Fixed-rate periods: tick_rate / 100 and tick_rate / 50.
  assign sq_prod     = 34'(tick_rate_r) * 34'(SQUARE_RECIP);
  assign ramp_prod   = 35'(tick_rate_r) * 35'(RAMP_RECIP);
  assign sq_period   = {6'd0, sq_prod[RECIP_SHIFT +: 10]};
  assign ramp_period = {5'd0, ramp_prod[RECIP_SHIFT +: 11]};

  // Tuned frequency: level * 900 / 4095 + 100, taken as level * 20 / 91 + 100.
  assign lvl_x20  = 17'(in_level) * 17'(HZ_STEP);
  assign hz_prod  = 34'(lvl_x20) * 34'(HZ_RECIP);
  assign hz       = hz_prod[RECIP_SHIFT +: 10] + HZ_OFFSET;

  assign scale_k  = (wave_r == WAVE_SAW) ? {1'b0, DAC_MAX} : TRI_SPAN;
  assign ramp_d   = div_rsp.quot[12:0];
  assign tri_v    = (prog_r < (period_r >> 1)) ? ramp_d : TRI_SPAN - ramp_d;

  wfg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt  = state_r;
    wave_nxt   = wave_r;
    period_nxt = period_r;
    prog_nxt   = prog_r;
    res_nxt    = res_r;
    out_load   = 1'b0;
    div_req    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          wave_nxt = in_wave;
          case (in_wave)
            WAVE_LEVEL: begin
              res_nxt   = in_level;
              state_nxt = ST_DONE;
            end
            WAVE_FULL: begin
              res_nxt   = DAC_MAX;
              state_nxt = ST_DONE;
            end
            WAVE_SQUARE, WAVE_SAW, WAVE_TRI: begin
              period_nxt = (in_wave == WAVE_SQUARE) ? sq_period : ramp_period;
              if (period_nxt == 16'd0) begin
                res_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = in_tdata[31:0];
                div_req.divisor  = period_nxt;
                state_nxt        = ST_MOD;
              end
            end
            WAVE_TRI_VAR: begin
              div_req.start    = 1'b1;
              div_req.dividend = {16'd0, tick_rate_r};
              div_req.divisor  = {6'd0, hz};
              state_nxt        = ST_PER;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_PER: begin
        if (div_rsp.done) begin
          period_nxt = div_rsp.quot[15:0];
          if (div_rsp.quot[15:0] == 16'd0) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = time_r;
            div_req.divisor  = div_rsp.quot[15:0];
            state_nxt        = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          prog_nxt = div_rsp.rem;
          if (wave_r == WAVE_SQUARE) begin
            res_nxt   = (div_rsp.rem > (period_r >> 1)) ? level_r : 12'd0;
            state_nxt = ST_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = {3'd0, 29'(div_rsp.rem) * 29'(scale_k)};
            div_req.divisor  = period_r;
            state_nxt        = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (div_rsp.done) begin
          if (wave_r == WAVE_SAW) begin
            res_nxt = ramp_d[11:0];
          end else begin
            // An odd period can push the falling edge past full scale.
            res_nxt = (tri_v > {1'b0, DAC_MAX}) ? DAC_MAX : tri_v[11:0];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wave_r      <= '0;
      tick_rate_r <= TICK_RATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wave_r      <= wave_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tick_rate_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      time_r  <= in_tdata[31:0];
      level_r <= in_level;
    end
    period_r <= period_nxt;
    prog_r   <= prog_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_value_r <= res_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, DAC_CTRL | {2'b00, out_value_r}, out_value_r};

endmodule

>>> design/wfg_div.sv
// ----------------------------------------------------------------------------
// wfg_div
// Restoring radix-2 divider, one quotient bit per cycle. A request is taken
// when start is high; done pulses once the quotient and remainder are ready.
// ----------------------------------------------------------------------------
module wfg_div
  import wfg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  wfg_div_req_t req,
  output wfg_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W+1:0]  trial;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {1'b0, rem_r, dvd_r[DIVIDEND_W-1]} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!trial[DIVISOR_W+1]) begin
        rem_r <= trial[DIVISOR_W-1:0];
        dvd_r <= {dvd_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DIVISOR_W-2:0], dvd_r[DIVIDEND_W-1]};
        dvd_r <= {dvd_r[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

>>> design/wfg_checker.sv
// ----------------------------------------------------------------------------
// wfg_checker
// Port-level checks for the multi-mode waveform generator, bound to the top.
// ----------------------------------------------------------------------------
module wfg_checker
  import wfg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // While a result is valid, the DAC word carries the control bits over the DAC code.
  a_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:12] == (DAC_CTRL | {2'b00, out_tdata[11:0]}))
    else $error("dac_word does not match dac_level");

  // After an input transfer, in_tready is low in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind multi_mode_waveform_generator wfg_checker u_wfg_checker (.*);
